// File: design/fqu_pkg.sv
package fqu_pkg;

    localparam int LAM_W     = 24;
    localparam int AMP_W     = 17;
    localparam int ANG_W     = 16;
    localparam int ROT_W     = 24;
    localparam int SPR_W     = 24;
    localparam int OUT_W     = 19;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PH_W      = 32;
    localparam int TRIG_W    = 32;
    localparam int DAMP_W    = 31;
    localparam int N_COMP    = 2;

    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [30:0] ONE30      = 31'h4000_0000;
    localparam logic [33:0] SL_LIMIT   = 34'd50331648;
    localparam logic [5:0]  SHIFT_LIMIT = 6'd17;
    localparam logic [OUT_W-1:0] SAT_MAG = 19'd131072;
    localparam logic [AMP_W-1:0] AMP_ONE_RST = 17'd65536;

    localparam logic [30:0] SIN_COEF [6] = '{
        31'd1686629713, 31'd693598668, 31'd85569306,
        31'd5026995, 31'd172272, 31'd3864
    };

    localparam int SIN_STEPS = 5;
    localparam int EXP_TERMS = 10;
    localparam int PHASE_LAT = 3;
    localparam int SINE_LAT  = SIN_STEPS + 4;
    localparam int DAMP_LAT  = 4 + 2 * EXP_TERMS + 1;
    localparam int TRIG_SKEW = DAMP_LAT + 1 - PHASE_LAT - SINE_LAT;
    localparam int PIPE_LAT  = DAMP_LAT + 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMP_ONE    = 3'd0,
        CFG_AMP_TWO    = 3'd1,
        CFG_ANGLE_ONE  = 3'd2,
        CFG_ANGLE_TWO  = 3'd3,
        CFG_ROT_ONE    = 3'd4,
        CFG_ROT_TWO    = 3'd5,
        CFG_SPREAD_ONE = 3'd6,
        CFG_SPREAD_TWO = 3'd7
    } t_cfg_idx;

    // multiply-and-shift constants for exact floor division of a 30-bit value
    function automatic logic [30:0] recip_mult(int k);
        logic [30:0] m;
        case (k)
            3:       m = 31'd1431655766;
            5:       m = 31'd1717986919;
            6:       m = 31'd1431655766;
            7:       m = 31'd1227133514;
            9:       m = 31'd1908874354;
            10:      m = 31'd1717986919;
            default: m = ONE30;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] recip_shift(int k);
        logic [5:0] s;
        case (k)
            1:       s = 6'd30;
            2:       s = 6'd31;
            3:       s = 6'd32;
            4:       s = 6'd32;
            9:       s = 6'd34;
            10:      s = 6'd34;
            default: s = 6'd33;
        endcase
        return s;
    endfunction

endpackage

// File: design/fqu_in_if.sv
interface fqu_in_if import fqu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LAM_W-1:0] wavelength_sq;

    modport source (output valid, output wavelength_sq, input ready);
    modport sink (input valid, input wavelength_sq, output ready);
endinterface

// File: design/fqu_out_if.sv
interface fqu_out_if import fqu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] stokes_q;
    logic signed [OUT_W-1:0] stokes_u;

    modport source (output valid, output stokes_q, output stokes_u, input ready);
    modport sink (input valid, input stokes_q, input stokes_u, output ready);
endinterface

// File: design/fqu_phase.sv
module fqu_phase import fqu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [LAM_W-1:0]        i_lam,
    input  logic signed [ROT_W-1:0] i_rot,
    input  logic [ANG_W-1:0]        i_angle,
    output logic [PH_W-1:0]         o_ph
);

    logic signed [47:0] r_prod;
    logic [54:0]        r_lo;
    logic [39:0]        r_hi;
    logic [PH_W-1:0]    r_ph;

    logic signed [48:0] w_prod;
    logic [54:0]        w_lo;
    logic signed [55:0] w_hi;
    logic [63:0]        w_sum;

    assign w_prod = i_rot * $signed({1'b0, i_lam});
    assign w_lo   = r_prod[23:0] * INV_PI_Q32;
    assign w_hi   = $signed(r_prod[47:24]) * $signed({1'b0, INV_PI_Q32});
    assign w_sum  = {9'd0, r_lo} + {r_hi, 24'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod[47:0];
            r_lo   <= w_lo;
            r_hi   <= w_hi[39:0];
            r_ph   <= w_sum[63:32] + {i_angle, 16'd0};
        end
    end

    assign o_ph = r_ph;

endmodule

// File: design/fqu_sine.sv
module fqu_sine import fqu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [PH_W-1:0]          i_ph,
    output logic signed [TRIG_W-1:0] o_sin
);

    logic [30:0]               r_xd  [SINE_LAT-2];
    logic [30:0]               r_x2d [SIN_STEPS];
    logic signed [32:0]        r_t   [SIN_STEPS];
    logic [SINE_LAT-2:0]       r_negd;
    logic signed [32:0]        r_p;
    logic signed [TRIG_W-1:0]  r_sin;

    logic [30:0]               w_x;
    logic [61:0]               w_xx;
    logic signed [32:0]        w_prev [SIN_STEPS];
    logic signed [64:0]        w_tx2  [SIN_STEPS];
    logic signed [32:0]        w_t    [SIN_STEPS];
    logic signed [64:0]        w_tx;
    logic [30:0]               w_mag;

    assign w_x  = i_ph[30] ? ONE30 - {1'b0, i_ph[29:0]} : {1'b0, i_ph[29:0]};
    assign w_xx = r_xd[0] * r_xd[0];

    for (genvar j = 0; j < SIN_STEPS; j++) begin : g_step
        if (j == 0) begin : g_first
            assign w_prev[j] = $signed({2'b00, SIN_COEF[SIN_STEPS]});
        end else begin : g_next
            assign w_prev[j] = r_t[j-1];
        end
        assign w_tx2[j] = w_prev[j] * $signed({1'b0, r_x2d[j]});
        assign w_t[j]   = $signed({2'b00, SIN_COEF[SIN_STEPS-1-j]}) - $signed(w_tx2[j][62:30]);
    end

    assign w_tx = r_t[SIN_STEPS-1] * $signed({1'b0, r_xd[SINE_LAT-3]});

    always_comb begin
        if (r_p < 0) begin
            w_mag = '0;
        end else if (r_p > $signed({2'b00, ONE30})) begin
            w_mag = ONE30;
        end else begin
            w_mag = r_p[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0]   <= w_x;
            r_negd[0] <= i_ph[31];
            for (int i = 1; i < SINE_LAT - 2; i++) begin
                r_xd[i] <= r_xd[i-1];
            end
            for (int i = 1; i < SINE_LAT - 1; i++) begin
                r_negd[i] <= r_negd[i-1];
            end
            r_x2d[0] <= w_xx[60:30];
            for (int i = 1; i < SIN_STEPS; i++) begin
                r_x2d[i] <= r_x2d[i-1];
            end
            for (int i = 0; i < SIN_STEPS; i++) begin
                r_t[i] <= w_t[i];
            end
            r_p   <= w_tx[62:30];
            r_sin <= r_negd[SINE_LAT-2] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign o_sin = r_sin;

endmodule

// File: design/fqu_damp.sv
module fqu_damp import fqu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [LAM_W-1:0]  i_lam,
    input  logic [SPR_W-1:0]  i_spread,
    output logic [DAMP_W-1:0] o_damp
);

    typedef struct packed {
        logic       under;
        logic [4:0] shift;
    } t_damp_meta;

    localparam int META_LEN = 2 * EXP_TERMS + 2;

    logic [33:0]       r_sl;
    logic [32:0]       r_a;
    logic              r_under;
    logic [27:0]       r_f;
    logic [29:0]       r_g;
    t_damp_meta        r_meta [META_LEN];
    logic [29:0]       r_v  [EXP_TERMS];
    logic [29:0]       r_vg [EXP_TERMS];
    logic [30:0]       r_t  [EXP_TERMS];
    logic [29:0]       r_tg [EXP_TERMS-1];
    logic [DAMP_W-1:0] r_damp;

    logic [47:0]       w_slp;
    logic [51:0]       w_sq;
    logic [63:0]       w_yp;
    logic [33:0]       w_y;
    logic [59:0]       w_gp;
    logic [30:0]       w_tprev [EXP_TERMS];
    logic [29:0]       w_gprev [EXP_TERMS];
    logic [60:0]       w_gt    [EXP_TERMS];
    logic [60:0]       w_vm    [EXP_TERMS];
    logic [29:0]       w_quo   [EXP_TERMS];

    assign w_slp = i_spread * i_lam;
    assign w_sq  = r_sl[25:0] * r_sl[25:0];
    assign w_yp  = r_a * LOG2E_Q30;
    assign w_y   = w_yp[63:30];
    assign w_gp  = r_f * LN2_Q32;

    for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
        if (j == 0) begin : g_first
            assign w_tprev[j] = ONE30;
            assign w_gprev[j] = r_g;
        end else begin : g_next
            assign w_tprev[j] = r_t[j-1];
            assign w_gprev[j] = r_tg[j-1];
        end
        assign w_gt[j]  = w_gprev[j] * w_tprev[j];
        assign w_vm[j]  = r_v[j] * recip_mult(EXP_TERMS - j);
        assign w_quo[j] = 30'(w_vm[j] >> recip_shift(EXP_TERMS - j));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sl    <= w_slp[47:14];
            r_a     <= w_sq[51:19];
            r_under <= (r_sl >= SL_LIMIT);
            r_f     <= w_y[27:0];
            r_meta[0].under <= r_under || (w_y[33:28] >= SHIFT_LIMIT);
            r_meta[0].shift <= w_y[32:28];
            for (int i = 1; i < META_LEN; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
            r_g <= w_gp[59:30];
            for (int i = 0; i < EXP_TERMS; i++) begin
                r_v[i]  <= w_gt[i][59:30];
                r_vg[i] <= w_gprev[i];
                r_t[i]  <= ONE30 - {1'b0, w_quo[i]};
            end
            for (int i = 0; i < EXP_TERMS - 1; i++) begin
                r_tg[i] <= r_vg[i];
            end
            r_damp <= r_meta[META_LEN-1].under ? '0 :
                      (r_t[EXP_TERMS-1] >> r_meta[META_LEN-1].shift);
        end
    end

    assign o_damp = r_damp;

endmodule

// File: design/faraday_qu_two_component_unit.sv
// One beat per cycle is sustained while the output buffer is not full, with
// fully pipelined multipliers.
// Depth is set by the damping exponential: ten series terms of two stages each.
// A two-entry output buffer stalls the whole pipeline only when it is full.
// Reset (synchronous, active low) clears pipeline valid bits and the output
// buffer, and returns the registers to amp_one = 1.0, all others zero.
module faraday_qu_two_component_unit import fqu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fqu_in_if.sink               i_wl,
    fqu_out_if.source            o_st,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [AMP_W-1:0]        r_amp    [N_COMP];
    logic [ANG_W-1:0]        r_angle  [N_COMP];
    logic signed [ROT_W-1:0] r_rot    [N_COMP];
    logic [SPR_W-1:0]        r_spread [N_COMP];

    logic [PIPE_LAT:1]       r_vld;
    logic [LAM_W-1:0]        r_lamd [TRIG_SKEW];
    logic [17:0]             r_m    [N_COMP];
    logic signed [48:0]      r_term [N_COMP][2];
    logic signed [48:0]      r_sum  [2];
    logic [48:0]             r_mag  [2];
    logic [1:0]              r_sgn;
    logic [OUT_W-1:0]        r_res  [2];

    logic [OUT_W-1:0]        r_fbuf [2][2];
    logic                    r_wp;
    logic                    r_rp;
    logic [1:0]              r_cnt;

    logic                    w_en;
    logic                    w_push;
    logic                    w_pop;
    logic [PH_W-1:0]         w_ph    [N_COMP];
    logic [DAMP_W-1:0]       w_damp  [N_COMP];
    logic signed [TRIG_W-1:0] w_trig [N_COMP][2];
    logic [47:0]             w_md    [N_COMP];
    logic signed [50:0]      w_tp    [N_COMP][2];
    logic [49:0]             w_rnd   [2];
    logic [OUT_W-1:0]        w_sat   [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp[0]    <= AMP_ONE_RST;
            r_amp[1]    <= '0;
            r_angle[0]  <= '0;
            r_angle[1]  <= '0;
            r_rot[0]    <= '0;
            r_rot[1]    <= '0;
            r_spread[0] <= '0;
            r_spread[1] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AMP_ONE:    r_amp[0]    <= i_cfg_data[AMP_W-1:0];
                CFG_AMP_TWO:    r_amp[1]    <= i_cfg_data[AMP_W-1:0];
                CFG_ANGLE_ONE:  r_angle[0]  <= i_cfg_data[ANG_W-1:0];
                CFG_ANGLE_TWO:  r_angle[1]  <= i_cfg_data[ANG_W-1:0];
                CFG_ROT_ONE:    r_rot[0]    <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_TWO:    r_rot[1]    <= i_cfg_data[ROT_W-1:0];
                CFG_SPREAD_ONE: r_spread[0] <= i_cfg_data[SPR_W-1:0];
                CFG_SPREAD_TWO: r_spread[1] <= i_cfg_data[SPR_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en   = (r_cnt != 2'd2);
    assign w_push = w_en && r_vld[PIPE_LAT];
    assign w_pop  = o_st.valid && o_st.ready;

    assign i_wl.ready = w_en;

    for (genvar k = 0; k < N_COMP; k++) begin : g_comp
        fqu_damp u_damp (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_lam    (i_wl.wavelength_sq),
            .i_spread (r_spread[k]),
            .o_damp   (w_damp[k])
        );

        fqu_phase u_phase (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_lam   (r_lamd[TRIG_SKEW-1]),
            .i_rot   (r_rot[k]),
            .i_angle (r_angle[k]),
            .o_ph    (w_ph[k])
        );

        fqu_sine u_cos (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ph  (w_ph[k] + 32'h4000_0000),
            .o_sin (w_trig[k][0])
        );

        fqu_sine u_sin (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ph  (w_ph[k]),
            .o_sin (w_trig[k][1])
        );

        assign w_md[k]    = r_amp[k] * w_damp[k];
        assign w_tp[k][0] = $signed({1'b0, r_m[k]}) * w_trig[k][0];
        assign w_tp[k][1] = $signed({1'b0, r_m[k]}) * w_trig[k][1];
    end

    for (genvar c = 0; c < 2; c++) begin : g_chan
        assign w_rnd[c] = {1'b0, r_mag[c]} + (50'd1 << 29);
        assign w_sat[c] = (w_rnd[c][49:30] > {1'b0, SAT_MAG}) ? SAT_MAG : w_rnd[c][48:30];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lamd[0] <= i_wl.wavelength_sq;
            for (int i = 1; i < TRIG_SKEW; i++) begin
                r_lamd[i] <= r_lamd[i-1];
            end
            for (int k = 0; k < N_COMP; k++) begin
                r_m[k]       <= w_md[k][47:30];
                r_term[k][0] <= w_tp[k][0][48:0];
                r_term[k][1] <= w_tp[k][1][48:0];
            end
            for (int c = 0; c < 2; c++) begin
                r_sum[c] <= r_term[0][c] + r_term[1][c];
                r_sgn[c] <= r_sum[c][48];
                r_mag[c] <= r_sum[c][48] ? 49'(-r_sum[c]) : 49'(r_sum[c]);
                r_res[c] <= r_sgn[c] ? -w_sat[c] : w_sat[c];
            end
        end
        if (w_push) begin
            r_fbuf[r_wp][0] <= r_res[0];
            r_fbuf[r_wp][1] <= r_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PIPE_LAT-1:1], i_wl.valid};
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_st.valid    = (r_cnt != 2'd0);
    assign o_st.stokes_q = r_fbuf[r_rp][0];
    assign o_st.stokes_u = r_fbuf[r_rp][1];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wl.valid && i_wl.ready |=> r_vld[1])
        else $error("accepted beat missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_LAT] && !w_en |=> r_vld[PIPE_LAT] && $stable(r_res[0])
            && $stable(r_res[1]))
        else $error("stalled result lost");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("push not counted");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_st.valid |-> $signed(o_st.stokes_q) <= $signed(SAT_MAG)
            && $signed(o_st.stokes_q) >= -$signed(SAT_MAG)
            && $signed(o_st.stokes_u) <= $signed(SAT_MAG)
            && $signed(o_st.stokes_u) >= -$signed(SAT_MAG))
        else $error("result beyond saturation limit");

endmodule
